/* rtl/tcw_pkg.sv */
package tcw_pkg;

    // Request codes carried on the request type input.
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FG = 2'd0;
    localparam logic [1:0] CFG_BG = 2'd1;

    localparam logic [3:0] FG_RESET = 4'd12;
    localparam logic [3:0] BG_RESET = 4'd0;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BLANK     = 8'd32;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_ZERO,
        ST_DONE
    } t_state;

    // One datapath operation per cycle, chosen by the controller.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_PUT,
        DP_CLR_START,
        DP_FILL,
        DP_RD,
        DP_SCR_RD,
        DP_SCR_WR,
        DP_ZERO,
        DP_EMIT,
        DP_EMIT_RD
    } t_dp_op;

    typedef struct packed {
        logic overflow;   // the put on the inputs runs past the last cell
        logic in_range;   // the read index addresses a real cell
        logic cnt_last;   // sweep counter is on the last cell
        logic copy_last;  // sweep counter is on the last cell of the scroll copy
    } t_stat;

    function automatic logic [15:0] make_cell(input logic [3:0] bg, input logic [3:0] fg,
                                              input logic [7:0] ch);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

/* rtl/text_console_writer_unit.sv */
// A put with no scroll, a read or an unused request goes via the DONE or READ state to the result
// register; no request is taken while busy. A put that scrolls copies the screen up a row with
// a read state and a write state per cell through the single read port and single write port
// of the screen memory, then zeroes the last row. A clear fills every cell with a blank in the
// current colors, one cell per cycle. Reset (synchronous, active low) starts a zeroing pass over
// every cell with busy high. The result strobe lasts one cycle and the receiver cannot stall it.
module text_console_writer_unit #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel: a request is taken at an edge with start high and busy low.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    // Configuration write port: index 0 is the foreground color, index 1 the background.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // Result channel.
    output logic        o_result_valid,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_pos
);
    import tcw_pkg::*;

    // The controller picks one datapath operation per cycle; the datapath reports
    // back whether a put overflows the screen, whether a read index is valid and
    // where its sweep counter stands during fills, scroll copies and row clears.
    t_dp_op op;
    t_stat  stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_op       (op),
        .o_busy     (busy)
    );

    // The datapath owns the screen memory, the cursor with its column counter,
    // the color registers and the result register.
    tcw_dpath #(.ROWS(ROWS), .COLS(COLS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .o_result_valid (o_result_valid),
        .o_cell_value   (o_cell_value),
        .o_cursor_pos   (o_cursor_pos)
    );

endmodule

/* rtl/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcw_ctrl.sv */
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_req_type,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_dp_op o_op,
    output logic          o_busy
);
    import tcw_pkg::*;

    t_state r_state, n_state;
    logic   r_clear_req, n_clear_req;
    t_req   req;

    assign req = t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_clear_req <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clear_req <= n_clear_req;
        end
    end

    // Next state.
    always_comb begin
        n_state     = r_state;
        n_clear_req = r_clear_req;
        unique case (r_state)
            ST_FILL: begin
                if (i_stat.cnt_last) begin
                    n_state = r_clear_req ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    unique case (req)
                        REQ_PUT: begin
                            n_state = i_stat.overflow ? ST_SCR_RD : ST_DONE;
                        end
                        REQ_CLEAR: begin
                            n_state     = ST_FILL;
                            n_clear_req = 1'b1;
                        end
                        REQ_READ: begin
                            n_state = i_stat.in_range ? ST_READ : ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:   n_state = ST_IDLE;
            ST_SCR_RD: n_state = ST_SCR_WR;
            ST_SCR_WR: begin
                if (i_stat.copy_last) begin
                    n_state = ST_ZERO;
                end else begin
                    n_state = ST_SCR_RD;
                end
            end
            ST_ZERO: begin
                if (i_stat.cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_op   = DP_NONE;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_FILL:   o_op = DP_FILL;
            ST_IDLE: begin
                if (i_start) begin
                    unique case (req)
                        REQ_PUT:   o_op = DP_PUT;
                        REQ_CLEAR: o_op = DP_CLR_START;
                        REQ_READ:  o_op = i_stat.in_range ? DP_RD : DP_NONE;
                        default:   o_op = DP_NONE;
                    endcase
                end
            end
            ST_READ:   o_op = DP_EMIT_RD;
            ST_SCR_RD: o_op = DP_SCR_RD;
            ST_SCR_WR: o_op = DP_SCR_WR;
            ST_ZERO:   o_op = DP_ZERO;
            ST_DONE:   o_op = DP_EMIT;
            default:   o_op = DP_NONE;
        endcase
    end

endmodule

/* rtl/tcw_dpath.sv */
module tcw_dpath #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcw_pkg::t_dp_op i_op,
    output tcw_pkg::t_stat  o_stat,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [3:0]      i_cfg_data,
    input  logic [7:0]      i_char_code,
    input  logic [10:0]     i_cell_index,
    output logic            o_result_valid,
    output logic [15:0]     o_cell_value,
    output logic [10:0]     o_cursor_pos
);
    import tcw_pkg::*;

    localparam int NCELLS    = ROWS * COLS;
    localparam int AW        = $clog2(NCELLS);
    localparam int CLW       = $clog2(COLS);
    localparam int COPY_LAST = (ROWS - 1) * COLS - 1;
    localparam int LAST_ROW  = (ROWS - 1) * COLS;

    logic [3:0]    r_fg, r_bg;
    logic [AW-1:0] r_cur, n_cur;
    logic [CLW-1:0] r_col, n_col;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_fill, n_fill;
    logic          r_valid, n_valid;
    logic [15:0]   r_value, n_value;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    logic          is_bs, is_nl;
    logic [AW:0]   pos_next;
    logic [CLW-1:0] col_next;

    tcw_ram #(.WIDTH(16), .DEPTH(NCELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Cursor arithmetic for a put request.
    always_comb begin
        is_bs = (i_char_code == CH_BACKSPACE) && (r_cur != '0);
        is_nl = (i_char_code == CH_NEWLINE);
        if (is_bs) begin
            pos_next = (AW+1)'(r_cur) - (AW+1)'(1);
            col_next = (r_col == '0) ? CLW'(COLS - 1) : r_col - CLW'(1);
        end else if (is_nl) begin
            pos_next = (AW+1)'(r_cur) - (AW+1)'(r_col) + (AW+1)'(COLS);
            col_next = '0;
        end else begin
            pos_next = (AW+1)'(r_cur) + (AW+1)'(1);
            col_next = (r_col == CLW'(COLS - 1)) ? '0 : r_col + CLW'(1);
        end
    end

    assign o_stat.overflow  = (pos_next >= (AW+1)'(NCELLS));
    assign o_stat.in_range  = (32'(i_cell_index) < 32'(NCELLS));
    assign o_stat.cnt_last  = (r_cnt == AW'(NCELLS - 1));
    assign o_stat.copy_last = (r_cnt == AW'(COPY_LAST));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = r_fill;
        mem_raddr = AW'(r_cnt + AW'(COLS));
        n_cur     = r_cur;
        n_col     = r_col;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_valid   = 1'b0;
        n_value   = r_value;
        unique case (i_op)
            DP_NONE: begin
            end
            DP_PUT: begin
                mem_we    = !is_nl;
                mem_waddr = is_bs ? AW'(r_cur - AW'(1)) : r_cur;
                mem_wdata = make_cell(r_bg, r_fg, is_bs ? CH_BLANK : i_char_code);
                n_col     = col_next;
                if (o_stat.overflow) begin
                    n_cur = AW'(LAST_ROW);
                    n_cnt = '0;
                end else begin
                    n_cur = pos_next[AW-1:0];
                end
            end
            DP_CLR_START: begin
                n_cnt  = '0;
                n_fill = make_cell(r_bg, r_fg, CH_BLANK);
                n_cur  = '0;
                n_col  = '0;
            end
            DP_FILL: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
            end
            DP_RD: begin
                mem_raddr = AW'(i_cell_index);
            end
            DP_SCR_RD: begin
            end
            DP_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_cnt     = r_cnt + AW'(1);
            end
            DP_ZERO: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_cnt     = r_cnt + AW'(1);
            end
            DP_EMIT: begin
                n_valid = 1'b1;
                n_value = '0;
            end
            DP_EMIT_RD: begin
                n_valid = 1'b1;
                n_value = mem_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= FG_RESET;
            r_bg    <= BG_RESET;
            r_cur   <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_FG)) begin
                r_fg <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_BG)) begin
                r_bg <= i_cfg_data;
            end
            r_cur   <= n_cur;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_result_valid = r_valid;
    assign o_cell_value   = r_value;
    assign o_cursor_pos   = 11'(r_cur);

endmodule

/* rtl/tcw_checker.sv */
module tcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [15:0] o_cell_value,
    input logic [10:0] o_cursor_pos
);

    // Reset always begins the screen zeroing pass.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // An accepted request keeps the block busy until its result is out.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Results appear only once the block has gone idle again.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // Each request gives a single one-cycle result.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    // Every result carries fully known values.
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !$isunknown({o_cell_value, o_cursor_pos}))
        else $error("result carries unknown bits");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_cell_value   (o_cell_value),
    .o_cursor_pos   (o_cursor_pos)
);
